// ===== hdl/nkht_pkg.sv =====
// types and constants shared by the name-keyed hash table
package nkht_pkg;

   localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
   localparam logic [31:0] FNV_PRIME = 32'h01000193;

   localparam logic [1:0] KIND_REGISTER   = 2'd0;
   localparam logic [1:0] KIND_LOOKUP     = 2'd1;
   localparam logic [1:0] KIND_UNREGISTER = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] key_name;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] cell_index;
      logic [8:0] live_count;
   } rsp_type;

   // front to back: normalized name with its full 32-bit hash
   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] name;
      logic [31:0] hash;
   } job_type;

   typedef enum logic [1:0] {
      HS_IDLE,
      HS_STEP,
      HS_DONE
   } hash_state_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_FIND_RD,
      BK_FIND_WAIT,
      BK_FIND_CMP,
      BK_DECIDE,
      BK_INS_RD,
      BK_INS_CHK,
      BK_DEL_RD,
      BK_DEL_NAME,
      BK_DEL_HASH,
      BK_DEL_WAIT,
      BK_DEL_CHK,
      BK_REPLY
   } back_state_type;

   // one FNV-1a byte step
   function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] x;
      x = h ^ {24'd0, b};
      return x * FNV_PRIME;
   endfunction

endpackage

// ===== hdl/nkht_hash.sv =====
// front end: name normalization and serial fnv-1a hash, one byte per cycle
module nkht_hash #(
   parameter int NAME_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  nkht_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output nkht_pkg::job_type out_data
);
   nkht_pkg::hash_state_type state_ff, state_in;
   logic [1:0]  kind_ff, kind_in;
   logic [63:0] name_ff, name_in;
   logic [31:0] hash_ff, hash_in;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  cur_byte;

   // keep bytes before the first zero byte, below NAME_BYTES
   function automatic logic [63:0] norm_name(input logic [63:0] k);
      logic [63:0] r;
      logic        stop;
      r = '0;
      stop = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (i >= NAME_BYTES || k[8*i +: 8] == 8'd0) stop = 1'b1;
         if (!stop) r[8*i +: 8] = k[8*i +: 8];
      end
      return r;
   endfunction

   assign cur_byte  = name_ff[{pos_ff, 3'b000} +: 8];
   assign in_ready  = (state_ff == nkht_pkg::HS_IDLE);
   assign out_valid = (state_ff == nkht_pkg::HS_DONE);
   assign out_data  = '{kind: kind_ff, name: name_ff, hash: hash_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nkht_pkg::HS_IDLE: if (in_valid) state_in = nkht_pkg::HS_STEP;
         nkht_pkg::HS_STEP: if (cur_byte == 8'd0 || pos_ff == 3'd7) state_in = nkht_pkg::HS_DONE;
         nkht_pkg::HS_DONE: if (out_ready) state_in = nkht_pkg::HS_IDLE;
         default: state_in = nkht_pkg::HS_IDLE;
      endcase
   end

   always_comb begin
      kind_in = kind_ff;
      name_in = name_ff;
      hash_in = hash_ff;
      pos_in  = pos_ff;
      case (state_ff)
         nkht_pkg::HS_IDLE: begin
            kind_in = in_data.kind;
            name_in = norm_name(in_data.key_name);
            hash_in = nkht_pkg::FNV_BASIS;
            pos_in  = 3'd0;
         end
         nkht_pkg::HS_STEP: begin
            if (cur_byte != 8'd0) hash_in = nkht_pkg::fnv_step(hash_ff, cur_byte);
            pos_in = pos_ff + 3'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= nkht_pkg::HS_IDLE;
      else       state_ff <= state_in;
      kind_ff <= kind_in;
      name_ff <= name_in;
      hash_ff <= hash_in;
      pos_ff  <= pos_in;
   end
endmodule

// ===== hdl/nkht_queue.sv =====
// two-entry job queue between front and back
module nkht_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  nkht_pkg::job_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output nkht_pkg::job_type out_data
);
   nkht_pkg::job_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

// ===== hdl/nkht_back.sv =====
// back end: slot table, name store, free list and the operation sequencer
module nkht_back #(
   parameter int CAPACITY = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  nkht_pkg::job_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output nkht_pkg::rsp_type out_data
);
   localparam int CW = $clog2(CAPACITY);
   localparam int SLOTS = 2 * CAPACITY;
   localparam int SW = $clog2(SLOTS);
   localparam logic [CW:0] NONE = CAPACITY[CW:0];
   localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);

   // memories
   logic [CW:0]   slot_mem [SLOTS];
   logic [63:0]   name_mem [CAPACITY];
   logic [CW:0]   link_mem [CAPACITY];
   logic [CW:0]   slot_rd_ff;
   logic [63:0]   name_rd_ff;
   logic [CW:0]   link_rd_ff;

   nkht_pkg::back_state_type state_ff, state_in;
   nkht_pkg::job_type job_ff;
   logic [SW-1:0] ptr_ff, ptr_in;     // probe / scan pointer
   logic [SW-1:0] hole_ff, hole_in;
   logic [SW-1:0] home_ff;
   logic [CW:0]   cell_ff, cell_in;
   logic [CW:0]   mov_ff, mov_in;     // cell under test in the shift pass
   logic          found_ff, found_in;
   logic [1:0]    status_ff, status_in;
   logic [CW:0]   head_ff, head_in;
   logic [CW:0]   count_ff, count_in;
   logic [CW:0]   init_ff;            // free links initialized below this
   logic [SW:0]   clr_ff;
   logic [SW-1:0] hash_slot_ff;
   logic [31:0]   rehash_ff;
   logic [2:0]    hpos_ff;

   // ram control
   logic          slot_we;
   logic [SW-1:0] slot_wa, slot_ra;
   logic [CW:0]   slot_wd;
   logic          name_we;
   logic [CW-1:0] name_wa, name_ra;
   logic          link_we;
   logic [CW-1:0] link_wa, link_ra;
   logic [CW:0]   link_wd;
   logic [CW:0]   head_link;
   logic [SW-1:0] ptr_next;
   logic [SW-1:0] d_k, d_hole;
   logic [7:0]    rh_byte;

   assign ptr_next = (ptr_ff == SLOT_LAST) ? '0 : ptr_ff + 1'b1;
   // free link of a cell never pushed reads as index plus one
   assign head_link = (head_ff >= init_ff) ? head_ff + 1'b1 : link_rd_ff;
   assign d_k    = SW'((ptr_ff + SLOTS - hash_slot_ff) % SLOTS);
   assign d_hole = SW'((ptr_ff + SLOTS - hole_ff) % SLOTS);
   assign rh_byte = name_rd_ff[{hpos_ff, 3'b000} +: 8];

   assign in_ready  = (state_ff == nkht_pkg::BK_IDLE);
   assign out_valid = (state_ff == nkht_pkg::BK_REPLY);
   assign out_data.status     = status_ff;
   assign out_data.cell_index = (status_ff == nkht_pkg::STATUS_OK) ? 8'(cell_ff) : 8'd0;
   assign out_data.live_count = 9'(count_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nkht_pkg::BK_CLEAR:    if (clr_ff == SLOTS[SW:0]) state_in = nkht_pkg::BK_IDLE;
         nkht_pkg::BK_IDLE:     if (in_valid) state_in = nkht_pkg::BK_FIND_RD;
         nkht_pkg::BK_FIND_RD:   state_in = nkht_pkg::BK_FIND_WAIT;
         nkht_pkg::BK_FIND_WAIT: state_in = nkht_pkg::BK_FIND_CMP;
         nkht_pkg::BK_FIND_CMP: begin
            if (slot_rd_ff >= NONE)                     state_in = nkht_pkg::BK_DECIDE;
            else if (name_rd_ff == job_ff.name)         state_in = nkht_pkg::BK_DECIDE;
            else                                        state_in = nkht_pkg::BK_FIND_RD;
         end
         nkht_pkg::BK_DECIDE: begin
            if (job_ff.kind == nkht_pkg::KIND_REGISTER && !found_ff && head_ff < NONE)
               state_in = nkht_pkg::BK_INS_RD;
            else if (job_ff.kind == nkht_pkg::KIND_UNREGISTER && found_ff)
               state_in = nkht_pkg::BK_DEL_RD;
            else
               state_in = nkht_pkg::BK_REPLY;
         end
         nkht_pkg::BK_INS_RD:  state_in = nkht_pkg::BK_INS_CHK;
         nkht_pkg::BK_INS_CHK: if (slot_rd_ff >= NONE) state_in = nkht_pkg::BK_REPLY;
                               else state_in = nkht_pkg::BK_INS_RD;
         nkht_pkg::BK_DEL_RD:   state_in = nkht_pkg::BK_DEL_NAME;
         nkht_pkg::BK_DEL_NAME: if (slot_rd_ff >= NONE) state_in = nkht_pkg::BK_REPLY;
                                else state_in = nkht_pkg::BK_DEL_WAIT;
         nkht_pkg::BK_DEL_WAIT: state_in = nkht_pkg::BK_DEL_HASH;
         nkht_pkg::BK_DEL_HASH:
            if (rh_byte == 8'd0 || hpos_ff == 3'd7) state_in = nkht_pkg::BK_DEL_CHK;
         nkht_pkg::BK_DEL_CHK:  state_in = nkht_pkg::BK_DEL_RD;
         nkht_pkg::BK_REPLY:    if (out_ready) state_in = nkht_pkg::BK_IDLE;
         default: state_in = nkht_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      ptr_in = ptr_ff; hole_in = hole_ff; cell_in = cell_ff; mov_in = mov_ff;
      found_in = found_ff; status_in = status_ff; head_in = head_ff; count_in = count_ff;
      slot_we = 1'b0; slot_wa = ptr_ff; slot_wd = NONE; slot_ra = ptr_ff;
      name_we = 1'b0; name_wa = CW'(head_ff); name_ra = CW'(slot_rd_ff);
      link_we = 1'b0; link_wa = CW'(cell_ff); link_wd = head_ff; link_ra = CW'(head_ff);
      case (state_ff)
         nkht_pkg::BK_CLEAR: begin
            slot_we = (clr_ff != SLOTS[SW:0]);
            slot_wa = SW'(clr_ff);
         end
         nkht_pkg::BK_IDLE: begin
            ptr_in   = SW'(in_data.hash % SLOTS);
            found_in = 1'b0;
         end
         nkht_pkg::BK_FIND_CMP: begin
            if (slot_rd_ff < NONE && name_rd_ff == job_ff.name) begin
               found_in = 1'b1;
               cell_in  = slot_rd_ff;
            end else if (slot_rd_ff < NONE) begin
               ptr_in = ptr_next;
            end
         end
         nkht_pkg::BK_DECIDE: begin
            status_in = nkht_pkg::STATUS_NOT_FOUND;
            case (job_ff.kind)
               nkht_pkg::KIND_REGISTER: begin
                  if (found_ff)            status_in = nkht_pkg::STATUS_DUPLICATE;
                  else if (head_ff >= NONE) status_in = nkht_pkg::STATUS_FULL;
                  else begin
                     status_in = nkht_pkg::STATUS_OK;
                     cell_in   = head_ff;
                     head_in   = head_link;
                     count_in  = count_ff + 1'b1;
                     name_we   = 1'b1;
                     ptr_in    = home_ff;
                  end
               end
               nkht_pkg::KIND_LOOKUP:
                  if (found_ff) status_in = nkht_pkg::STATUS_OK;
               nkht_pkg::KIND_UNREGISTER: begin
                  if (found_ff) begin
                     status_in = nkht_pkg::STATUS_OK;
                     link_we   = 1'b1;
                     head_in   = cell_ff;
                     count_in  = count_ff - 1'b1;
                     slot_we   = 1'b1;
                     hole_in   = ptr_ff;
                     ptr_in    = ptr_next;
                  end
               end
               default: ;
            endcase
         end
         nkht_pkg::BK_INS_CHK: begin
            if (slot_rd_ff >= NONE) begin
               slot_we = 1'b1;
               slot_wd = cell_ff;
            end else ptr_in = ptr_next;
         end
         nkht_pkg::BK_DEL_NAME: mov_in = slot_rd_ff;
         nkht_pkg::BK_DEL_CHK: begin
            if (d_k >= d_hole) begin
               slot_we = 1'b1; slot_wa = hole_ff; slot_wd = mov_ff;
               hole_in = ptr_ff;
            end
            ptr_in = ptr_next;
         end
         default: ;
      endcase
      // a moved entry leaves its old slot as the new hole; the last hole is cleared when the scan meets an empty slot
      if (state_ff == nkht_pkg::BK_DEL_NAME && slot_rd_ff >= NONE) begin
         slot_we = 1'b1; slot_wa = hole_ff; slot_wd = NONE;
      end
      if (state_ff == nkht_pkg::BK_DEL_NAME) name_ra = CW'(slot_rd_ff);
   end

   // state, datapath and memory registers, rehash for the shift pass and init sweep bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nkht_pkg::BK_CLEAR;
         clr_ff   <= '0;
         head_ff  <= '0;
         count_ff <= '0;
         init_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == nkht_pkg::BK_CLEAR && clr_ff != SLOTS[SW:0]) clr_ff <= clr_ff + 1'b1;
         head_ff  <= head_in;
         count_ff <= count_in;
         if (link_we && cell_ff >= init_ff) init_ff <= init_ff; // link now real in memory
         if (state_ff == nkht_pkg::BK_DECIDE && job_ff.kind == nkht_pkg::KIND_REGISTER
             && status_in == nkht_pkg::STATUS_OK && head_ff >= init_ff)
            init_ff <= head_ff + 1'b1;
      end
      if (state_ff == nkht_pkg::BK_IDLE) begin
         job_ff  <= in_data;
         home_ff <= SW'(in_data.hash % SLOTS);
      end
      ptr_ff <= ptr_in; hole_ff <= hole_in; cell_ff <= cell_in; mov_ff <= mov_in;
      found_ff <= found_in; status_ff <= status_in;
      if (state_ff == nkht_pkg::BK_DEL_WAIT) begin
         rehash_ff <= nkht_pkg::FNV_BASIS;
         hpos_ff   <= 3'd0;
      end else if (state_ff == nkht_pkg::BK_DEL_HASH) begin
         if (rh_byte != 8'd0) begin
            rehash_ff <= nkht_pkg::fnv_step(rehash_ff, rh_byte);
            hash_slot_ff <= SW'(nkht_pkg::fnv_step(rehash_ff, rh_byte) % SLOTS);
         end else hash_slot_ff <= SW'(rehash_ff % SLOTS);
         hpos_ff <= hpos_ff + 3'd1;
      end
      slot_rd_ff <= slot_mem[slot_ra];
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      name_rd_ff <= name_mem[name_ra];
      if (name_we) name_mem[name_wa] <= job_ff.name;
      link_rd_ff <= link_mem[link_ra];
      if (link_we) link_mem[link_wa] <= link_wd;
   end
endmodule

// ===== hdl/name_keyed_hash_table_with_free_list_unit.sv =====
// top level of the name-keyed hash table with free list
//
// channel   direction  payload               meaning
// req_      in         nkht_pkg::req_type    operation and name
// rsp_      out        nkht_pkg::rsp_type    status, cell and live count
//
// the front hashes one name byte per cycle
// the back probes the slot memory, each lookup probe through read, wait and compare
// states and each insert probe through read and check states; the backward-shift pass
// of unregister reads, rehashes and checks every slot it scans
// after reset the back sweeps all 2*CAPACITY slots of the slot memory before work
// a two-entry queue decouples front and back so each stalls on its own
module name_keyed_hash_table_with_free_list_unit #(
   parameter int CAPACITY   = 256,
   parameter int NAME_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nkht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nkht_pkg::rsp_type rsp_data
);
   // front to queue and queue to back
   logic              fq_valid, fq_ready, qb_valid, qb_ready;
   nkht_pkg::job_type fq_data, qb_data;

   // serial hash
   nkht_hash #(.NAME_BYTES(NAME_BYTES)) u_hash (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data),
      .out_valid(fq_valid), .out_ready(fq_ready), .out_data(fq_data)
   );

   // job queue
   nkht_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
   );

   // table engine
   nkht_back #(.CAPACITY(CAPACITY)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(qb_valid), .in_ready(qb_ready), .in_data(qb_data),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(rsp_data)
   );

`ifndef ASSERT_OFF
   // a non-ok result never carries a cell index
   a_cell_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != nkht_pkg::STATUS_OK |-> rsp_data.cell_index == 8'd0)
      else $error("cell index set on failed result");
   // live count never exceeds capacity
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.live_count <= 9'(CAPACITY))
      else $error("live count above capacity");
   // a result drops only by being taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped while stalled");
`endif
endmodule
